>>> rtl/nmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared widths, register map, divisor codes and types for the neighbor
// mean filter.
// ----------------------------------------------------------------------------
package nmf_pkg;

  localparam int PIX_W     = 16;
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 10;
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int SUM_W     = 19;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  // register map, indexed by paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FW_RESET = 11'd5;
  localparam logic [FH_W-1:0] FH_RESET = 12'd5;

  typedef logic [1:0] div_t;
  localparam div_t DIV_BY_8 = 2'd0;
  localparam div_t DIV_BY_5 = 2'd1;
  localparam div_t DIV_BY_3 = 2'd2;

  // floor(s/d) = (s * ceil(2^21/d)) >> 21, exact for s < 2^19
  localparam int              RECIP_W     = 20;
  localparam int              RECIP_SHIFT = 21;
  localparam logic [RECIP_W-1:0] RECIP_5  = 20'd419431;
  localparam logic [RECIP_W-1:0] RECIP_3  = 20'd699051;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
    logic                 done;
  } res_meta_t;

endpackage

>>> rtl/neighbor_mean_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_mean_filter_top
// Streaming 3x3 neighbor mean (center excluded) over a raster-order frame,
// with a two-row line store and an APB register port.
// ----------------------------------------------------------------------------
// Pixels enter one word per cycle while in_stall is low. A result for a
// position leaves as soon as its last neighbor has arrived: most pixels give
// one result, the pixel at a row end and each pixel of the last row give two,
// the frame's final pixel gives four, and pixels in row 0 or column 0 give
// none. The single result port sets the rate: a pixel that gives more than
// one result holds in_stall until its last result has moved on. The line
// store is read into the stage-1 registers at acceptance, the neighbor sum
// is registered into stage 2 and the divided mean into the output register,
// which drives out_valid. The line store holds two rows of MAX_WIDTH words in
// one memory with two read ports and one write port; it needs no clearing
// after reset.
// Writing frame_width or frame_height restarts the frame at position (0,0);
// write them only while the block is idle.
module neighbor_mean_filter_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [nmf_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nmf_pkg::PIX_W-1:0]      out_mean_value,
  output logic [nmf_pkg::ROW_W-1:0]      out_row,
  output logic [nmf_pkg::COL_OUT_W-1:0]  out_col,
  output logic                           out_last_in_run,
  output logic                           out_frame_done,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nmf_pkg::ADDR_W-1:0]     paddr,
  input  logic [nmf_pkg::DATA_W-1:0]     pwdata,
  output logic [nmf_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import nmf_pkg::*;

  localparam int CW       = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW       = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam int AW       = CW + 1;
  localparam int LS_DEPTH = 2 ** AW;
  localparam int PROD_W   = SUM_W + RECIP_W;

  // configuration
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic            cfg_wr;
  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(fw_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(fh_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (WW'(fw_r) < WW'(2)) begin
      w_eff = WW'(2);
    end else if (WW'(fw_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    h_eff = (fh_r < FH_W'(2)) ? FH_W'(2) : fh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  fw_r <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline control
  logic out_valid_r, s2_valid_r, s1_valid_r;
  logic out_valid_nxt, s2_valid_nxt, s1_valid_nxt;
  logic out_en, s2_en, s1_fire, s1_retire, in_accept;
  logic [3:0] pend_r, pend_nxt, pend_new, sel_bit;
  logic       pend_single;
  logic [1:0] sel;

  assign out_en      = ~out_valid_r | ~out_stall;
  assign s2_en       = ~s2_valid_r | out_en;
  assign pend_single = (pend_r != 4'd0) && ((pend_r & (pend_r - 4'd1)) == 4'd0);
  assign s1_fire     = s1_valid_r & (pend_r != 4'd0) & s2_en;
  assign s1_retire   = s1_valid_r & ((pend_r == 4'd0) | (s2_en & pend_single));
  assign in_stall    = s1_valid_r & ~s1_retire;
  assign in_accept   = in_valid & ~in_stall;

  // results in order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
  always_comb begin
    if (pend_r[0]) begin
      sel = 2'd0;
    end else if (pend_r[1]) begin
      sel = 2'd1;
    end else if (pend_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    sel_bit = 4'b0001 << sel;
  end

  // input position counters
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [WW-1:0]    col_inc;
  logic [ROW_W:0]   row_inc;
  logic             col_end, last_row, has_res;

  assign col_inc  = WW'(col_r) + WW'(1);
  assign row_inc  = {1'b0, row_r} + {{ROW_W{1'b0}}, 1'b1};
  assign col_end  = (col_inc == w_eff);
  assign last_row = (row_inc == {1'b0, h_eff});
  assign has_res  = (row_r != '0) && (col_r != '0);
  assign pend_new = has_res ? {col_end & last_row, last_row, col_end, 1'b1} : 4'd0;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_accept) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = in_accept | (s1_valid_r & ~s1_retire);
    s2_valid_nxt  = s1_fire | (s2_valid_r & ~out_en);
    out_valid_nxt = (s2_valid_r & out_en) | (out_valid_r & out_stall);
    if (in_accept) begin
      pend_nxt = pend_new;
    end else if (s1_fire) begin
      pend_nxt = pend_r & ~sel_bit;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 4'd0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // line store: row r-2 sits at the current row's parity, row r-1 at the other
  pix_t          line_mem [LS_DEPTH];
  logic [AW-1:0] addr_cur, addr_prev;
  pix_t          above2_r, above1_r, px_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_top_ok_r, s1_left_ok_r;

  assign addr_cur  = {row_r[0], col_r};
  assign addr_prev = {~row_r[0], col_r};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_mem[addr_cur] <= in_pixel;
      above2_r           <= line_mem[addr_cur];
      above1_r           <= line_mem[addr_prev];
      px_r               <= in_pixel;
      s1_row_r           <= row_r;
      s1_col_r           <= col_r;
      s1_top_ok_r        <= (row_r >= ROW_W'(2));
      s1_left_ok_r       <= (WW'(col_r) >= WW'(2));
    end
  end

  // window: two stored columns plus the freshly read one
  pix_t win_c0_r [3];
  pix_t win_c1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_c0_r[i] <= '0;
        win_c1_r[i] <= '0;
      end
    end else if (s1_retire) begin
      for (int i = 0; i < 3; i++) begin
        win_c0_r[i] <= win_c1_r[i];
      end
      win_c1_r[0] <= above2_r;
      win_c1_r[1] <= above1_r;
      win_c1_r[2] <= px_r;
    end
  end

  // neighbor sum for the selected center
  logic             cr_hi, cc_hi, row0_in, col0_in;
  logic [SUM_W-1:0] sum;
  div_t             div_code;
  res_meta_t        meta;
  logic [CW-1:0]    x_pos;

  assign cr_hi   = sel[1];
  assign cc_hi   = sel[0];
  assign row0_in = ~cr_hi & s1_top_ok_r;
  assign col0_in = ~cc_hi & s1_left_ok_r;

  always_comb begin
    pix_t win [3][3];
    logic row_in, col_in, ctr;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win_c0_r[i];
      win[i][1] = win_c1_r[i];
    end
    win[0][2] = above2_r;
    win[1][2] = above1_r;
    win[2][2] = px_r;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        row_in = (i != 0) || row0_in;
        col_in = (j != 0) || col0_in;
        ctr    = (i == (cr_hi ? 2 : 1)) && (j == (cc_hi ? 2 : 1));
        if (row_in && col_in && !ctr) begin
          sum = sum + SUM_W'(win[i][j]);
        end
      end
    end
  end

  always_comb begin
    if (row0_in && col0_in) begin
      div_code = DIV_BY_8;
    end else if (row0_in || col0_in) begin
      div_code = DIV_BY_5;
    end else begin
      div_code = DIV_BY_3;
    end
    x_pos     = cc_hi ? s1_col_r : s1_col_r - CW'(1);
    meta.row  = cr_hi ? s1_row_r : s1_row_r - ROW_W'(1);
    meta.col  = COL_OUT_W'(x_pos);
    meta.last = pend_single;
    meta.done = (sel == 2'd3);
  end

  logic [SUM_W-1:0] s2_sum_r;
  div_t             s2_div_r;
  res_meta_t        s2_meta_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_sum_r  <= sum;
      s2_div_r  <= div_code;
      s2_meta_r <= meta;
    end
  end

  // divide by constant count
  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  pix_t               mean;

  always_comb begin
    recip = (s2_div_r == DIV_BY_5) ? RECIP_5 : RECIP_3;
    prod  = PROD_W'(s2_sum_r) * PROD_W'(recip);
    case (s2_div_r)
      DIV_BY_8: mean = s2_sum_r[3 +: PIX_W];
      DIV_BY_5: mean = prod[RECIP_SHIFT +: PIX_W];
      DIV_BY_3: mean = prod[RECIP_SHIFT +: PIX_W];
      default:  mean = s2_sum_r[3 +: PIX_W];
    endcase
  end

  pix_t      out_mean_r;
  res_meta_t out_meta_r;

  always_ff @(posedge clk) begin
    if (s2_valid_r && out_en) begin
      out_mean_r <= mean;
      out_meta_r <= s2_meta_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mean_value  = out_mean_r;
  assign out_row         = out_meta_r.row;
  assign out_col         = out_meta_r.col;
  assign out_last_in_run = out_meta_r.last;
  assign out_frame_done  = out_meta_r.done;

endmodule
